### rtl/safc_pkg.sv
// Package: shared types and constants for the segment allocator.
`default_nettype none
package safc_pkg;
  localparam int unsigned MaxSegmentsDefault = 16;
  localparam int unsigned AddrBitsDefault    = 16;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned IdW    = 4;
  localparam int unsigned StatW  = 2;
  localparam int unsigned UsersW = 8;
  localparam int unsigned OutAddrW = 16;

  localparam logic [FuncW-1:0] FuncAlloc   = 2'd0;
  localparam logic [FuncW-1:0] FuncAttach  = 2'd1;
  localparam logic [FuncW-1:0] FuncRelease = 2'd2;
  localparam logic [FuncW-1:0] FuncCompact = 2'd3;

  localparam logic [StatW-1:0] StatOk        = 2'd0;
  localparam logic [StatW-1:0] StatNoSpace   = 2'd1;
  localparam logic [StatW-1:0] StatUnknown   = 2'd2;
  localparam logic [StatW-1:0] StatTableFull = 2'd3;

  // Per-cycle command broadcast to every cell in the chain.
  typedef struct packed {
    logic shift_up;    // take entry from lower neighbor
    logic shift_down;  // take entry from upper neighbor
    logic load_new;    // load the new entry at the insert slot
    logic rebase;      // take base from the running compaction address
  } cell_cmd_t;
endpackage
`default_nettype wire

### rtl/safc_cell.sv
// Module: one slot of the address-sorted segment list.
`default_nettype none
module safc_cell
  import safc_pkg::*;
#(
  parameter int unsigned NumW  = 4,
  parameter int unsigned BaseW = 16
) (
  input  wire logic             clk_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire logic             sel_i,   // this slot is the target of the command
  input  wire logic             above_i, // this slot lies above the target
  input  wire logic [NumW-1:0]  lo_num_i,
  input  wire logic [BaseW-1:0] lo_base_i,
  input  wire logic [SizeW-1:0] lo_len_i,
  input  wire logic [NumW-1:0]  hi_num_i,
  input  wire logic [BaseW-1:0] hi_base_i,
  input  wire logic [SizeW-1:0] hi_len_i,
  input  wire logic [NumW-1:0]  new_num_i,
  input  wire logic [BaseW-1:0] new_base_i,
  input  wire logic [SizeW-1:0] new_len_i,
  output logic      [NumW-1:0]  num_o,
  output logic      [BaseW-1:0] base_o,
  output logic      [SizeW-1:0] len_o
);
  logic [NumW-1:0]  num_q;
  logic [BaseW-1:0] base_q;
  logic [SizeW-1:0] len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_new && sel_i) begin
      num_q <= new_num_i; base_q <= new_base_i; len_q <= new_len_i;
    end else if (cmd_i.shift_up && above_i) begin
      num_q <= lo_num_i; base_q <= lo_base_i; len_q <= lo_len_i;
    end else if (cmd_i.shift_down && (sel_i || above_i)) begin
      num_q <= hi_num_i; base_q <= hi_base_i; len_q <= hi_len_i;
    end else if (cmd_i.rebase && sel_i) begin
      base_q <= new_base_i;
    end
  end

  assign num_o  = num_q;
  assign base_o = base_q;
  assign len_o  = len_q;
endmodule
`default_nettype wire

### rtl/segment_allocator_first_fit_compact.sv
// Top level: first-fit segment allocator with compaction over a chain of list cells.
// Operation: attach and release walk the list one slot per cycle until the matching entry;
//   compact rebases each entry in turn from the running address; allocate walks the free
//   numbers, scans for a gap, then inserts the entry or runs a compaction walk.
// Throughput: one transaction at a time; the next is taken once the result is consumed and,
//   after a freeing release, the list shift is done.
// Reset: rst_ni low clears the list count, in-use bits and user counts; memory_size gets 65536.
`default_nettype none
module segment_allocator_first_fit_compact
  import safc_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault,
  parameter int unsigned ADDR_BITS    = AddrBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SizeW-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FuncW-1:0]  func_i,
  input  wire logic [SizeW-1:0]  request_size_i,
  input  wire logic [IdW-1:0]    segment_id_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [StatW-1:0]       status_o,
  output logic [IdW-1:0]         result_segment_o,
  output logic [OutAddrW-1:0]    result_address_o,
  output logic [UsersW-1:0]      users_now_o
);
  localparam int unsigned NumW  = $clog2(MAX_SEGMENTS);
  localparam int unsigned CntW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned BaseW = ADDR_BITS;
  localparam int unsigned WideW = ADDR_BITS + 2;
  localparam logic [WideW-1:0] AddrCap = WideW'(1) << ADDR_BITS;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StFreeNum = 7'b0000010,
    StScan    = 7'b0000100,
    StShift   = 7'b0001000,
    StCompact = 7'b0010000,
    StFind    = 7'b0100000,
    StRemove  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [SizeW-1:0] mem_size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mem_size_q <= SizeW'(65536);
    else if (cfg_we_i) mem_size_q <= cfg_wdata_i;
  end

  // Limit is memory_size saturated at 2^ADDR_BITS.
  logic [WideW-1:0] limit;
  always_comb begin
    limit = (WideW'(mem_size_q) < AddrCap) ? WideW'(mem_size_q) : AddrCap;
  end

  // Latched transaction.
  logic [FuncW-1:0] func_q;
  logic [SizeW-1:0] size_q;
  logic [IdW-1:0]   id_q;
  logic [NumW-1:0]  id_idx;      // segment number sized to index the number tables
  assign id_idx = NumW'(id_q);

  // Control registers.
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q;       // walk pointer
  logic [NumW-1:0]  num_q;       // free-number search / new number
  logic [WideW-1:0] run_q;       // running address (gap start or compaction base)
  logic [MAX_SEGMENTS-1:0] in_use_q;
  logic [UsersW-1:0] users_q [MAX_SEGMENTS];
  logic [NumW-1:0]  hit_q;       // slot found for release

  // Result register.
  logic             out_valid_q;
  logic [StatW-1:0] st_q;
  logic [IdW-1:0]   rseg_q;
  logic [OutAddrW-1:0] raddr_q;
  logic [UsersW-1:0] rusers_q;

  // Cell chain wiring.
  logic [NumW-1:0]  c_num  [MAX_SEGMENTS];
  logic [BaseW-1:0] c_base [MAX_SEGMENTS];
  logic [SizeW-1:0] c_len  [MAX_SEGMENTS];
  cell_cmd_t        cmd;
  logic [NumW-1:0]  tgt;
  logic [BaseW-1:0] new_base;

  // Current cell at the walk pointer.
  logic [NumW-1:0]  cur_num;
  logic [BaseW-1:0] cur_base;
  logic [SizeW-1:0] cur_len;
  logic             at_end;
  always_comb begin
    cur_num  = c_num[idx_q[NumW-1:0]];
    cur_base = c_base[idx_q[NumW-1:0]];
    cur_len  = c_len[idx_q[NumW-1:0]];
    at_end   = (idx_q >= count_q);
  end

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    localparam int unsigned Lo = (g == 0) ? 0 : g - 1;
    localparam int unsigned Hi = (g == MAX_SEGMENTS - 1) ? g : g + 1;
    safc_cell #(.NumW(NumW), .BaseW(BaseW)) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .sel_i     (tgt == NumW'(g)),
      .above_i   (NumW'(g) > tgt),
      .lo_num_i  (c_num[Lo]),
      .lo_base_i (c_base[Lo]),
      .lo_len_i  (c_len[Lo]),
      .hi_num_i  (c_num[Hi]),
      .hi_base_i (c_base[Hi]),
      .hi_len_i  (c_len[Hi]),
      .new_num_i (num_q),
      .new_base_i(new_base),
      .new_len_i (size_q),
      .num_o     (c_num[g]),
      .base_o    (c_base[g]),
      .len_o     (c_len[g])
    );
  end

  // Gap test at the current cell: does the request fit below it?
  logic [WideW-1:0] fit_end;
  logic [WideW-1:0] cur_end;
  always_comb begin
    fit_end = run_q + WideW'(size_q);
    cur_end = WideW'(cur_base) + WideW'(cur_len);
  end

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;

  // Sequencer.
  logic             emit;
  logic [StatW-1:0] e_st;
  logic [IdW-1:0]   e_seg;
  logic [OutAddrW-1:0] e_addr;
  logic [UsersW-1:0] e_users;
  logic             go_compact;

  always_comb begin
    state_d = state_q;
    cmd = '0;
    tgt = idx_q[NumW-1:0];
    new_base = run_q[BaseW-1:0];
    emit = 1'b0;
    e_st = StatOk; e_seg = '0; e_addr = '0; e_users = '0;
    go_compact = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          unique case (func_i)
            FuncAlloc:   state_d = StFreeNum;
            FuncCompact: state_d = StCompact;
            default:     state_d = StFind;
          endcase
        end
      end
      StFreeNum: begin
        // Walk one segment number per cycle for the lowest free one.
        if (!in_use_q[num_q]) begin
          if (count_q >= CntW'(MAX_SEGMENTS)) begin
            emit = 1'b1; e_st = StatTableFull; state_d = StIdle;
          end else if (size_q == '0) begin
            go_compact = 1'b1; state_d = StCompact;
          end else begin
            state_d = StScan;
          end
        end else if (num_q == NumW'(MAX_SEGMENTS - 1)) begin
          emit = 1'b1; e_st = StatTableFull; state_d = StIdle;
        end
      end
      StScan: begin
        // First fit: stop at the first cell whose base clears the gap.
        if (at_end || (WideW'(cur_base) >= fit_end)) begin
          if (fit_end > limit) begin
            go_compact = 1'b1; state_d = StCompact;
          end else begin
            state_d = StShift;
          end
        end
      end
      StShift: begin
        // Open the slot at the insert point and load the new entry into it in one move.
        cmd.shift_up = 1'b1;
        cmd.load_new = 1'b1;
        emit = 1'b1; e_st = StatOk; e_seg = IdW'(num_q);
        e_addr = OutAddrW'(run_q); e_users = UsersW'(1);
        state_d = StIdle;
      end
      StCompact: begin
        // Rebase one cell per cycle from the running address.
        if (at_end || idx_q >= CntW'(MAX_SEGMENTS)) begin
          emit = 1'b1;
          e_st = (func_q == FuncAlloc) ? StatNoSpace : StatOk;
          state_d = StIdle;
        end else begin
          cmd.rebase = 1'b1;
        end
      end
      StFind: begin
        if (!in_use_q[id_idx] || (32'(id_q) >= MAX_SEGMENTS) || at_end) begin
          emit = 1'b1; e_st = StatUnknown; e_seg = id_q; state_d = StIdle;
        end else if (cur_num == id_idx) begin
          e_seg = id_q; e_addr = OutAddrW'(cur_base);
          if (func_q == FuncAttach) begin
            emit = 1'b1;
            if (users_q[id_idx] == '1) begin
              e_st = StatTableFull; e_users = '1;
            end else begin
              e_users = users_q[id_idx] + UsersW'(1);
            end
            state_d = StIdle;
          end else if (users_q[id_idx] > UsersW'(1)) begin
            emit = 1'b1;
            e_users = users_q[id_idx] - UsersW'(1);
            state_d = StIdle;
          end else begin
            emit = 1'b1; e_users = '0;
            state_d = StRemove;
          end
        end
      end
      StRemove: begin
        // Close the gap: every cell from the hit slot up takes its upper neighbor.
        tgt = hit_q;
        cmd.shift_down = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q <= '0;
      num_q <= '0;
      run_q <= '0;
      hit_q <= '0;
      in_use_q <= '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) users_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          idx_q <= '0; num_q <= '0; run_q <= '0;
        end
        StFreeNum: begin
          if (in_use_q[num_q] && num_q != NumW'(MAX_SEGMENTS - 1)) num_q <= num_q + NumW'(1);
          if (go_compact) begin
            idx_q <= '0; run_q <= '0;
          end
        end
        StScan: begin
          if (go_compact) begin
            idx_q <= '0; run_q <= '0;
          end else if (!(at_end || (WideW'(cur_base) >= fit_end))) begin
            run_q <= cur_end; idx_q <= idx_q + CntW'(1);
          end
        end
        StShift: begin
          count_q <= count_q + CntW'(1);
          in_use_q[num_q] <= 1'b1;
          users_q[num_q] <= UsersW'(1);
        end
        StCompact: begin
          if (!(at_end || idx_q >= CntW'(MAX_SEGMENTS))) begin
            run_q <= run_q + WideW'(cur_len);
            idx_q <= idx_q + CntW'(1);
          end
        end
        StFind: begin
          if (emit) begin
            if (e_st == StatOk) users_q[id_idx] <= e_users;
            if (state_d == StRemove) begin
              hit_q <= idx_q[NumW-1:0];
              in_use_q[id_idx] <= 1'b0;
            end
          end else begin
            idx_q <= idx_q + CntW'(1);
          end
        end
        StRemove: count_q <= count_q - CntW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers: transaction fields and result.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i; size_q <= request_size_i; id_q <= segment_id_i;
    end
    if (emit) begin
      st_q <= e_st; rseg_q <= e_seg; raddr_q <= e_addr; rusers_q <= e_users;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = st_q;
  assign result_segment_o = rseg_q;
  assign result_address_o = raddr_q;
  assign users_now_o      = rusers_q;
endmodule
`default_nettype wire

### rtl/safc_checker.sv
// Checker: port-level properties of the segment allocator, bound to the top level.
`default_nettype none
module safc_port_checker
  import safc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [StatW-1:0] status_o,
  input wire logic [UsersW-1:0] users_now_o,
  input wire logic [OutAddrW-1:0] result_address_o
);
  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_nospace_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatNoSpace |-> users_now_o == '0 && result_address_o == '0)
    else $error("no-space result carries data");
  a_accept_gives_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second transaction taken");
endmodule

bind segment_allocator_first_fit_compact safc_port_checker u_safc_port_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .status_o(status_o),
  .users_now_o(users_now_o), .result_address_o(result_address_o)
);
`default_nettype wire
